// ----- hw/rtl/l3fn_pkg.sv -----
// l3fn_pkg: shared types, constants and byte-sum helpers for the L3 forward/NAT block.
// No dependencies; imported by every l3fn module.
package l3fn_pkg;

    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 104;
    localparam int ADDR_W     = 3;
    localparam int SUM_W      = 24;
    localparam int HDR_SUM_W  = 13;

    localparam logic [31:0]      INDEX_MAX = 32'd63;
    localparam logic [SUM_W-1:0] SUM_CAP   = 24'hFF_FFFF;

    // item kinds carried on tuser
    localparam logic FUNC_HEADER  = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_NIC_ADDRESS   = 1'b0;
    localparam logic REG_PREFIX_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_INVALID     = 3'd0,
        VERDICT_LOCAL_DROP  = 3'd1,
        VERDICT_TTL_EXPIRED = 3'd2,
        VERDICT_LOCAL_L4    = 3'd3,
        VERDICT_TX_QUEUE    = 3'd4,
        VERDICT_RX_QUEUE    = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [31:0] nic_address;
        logic [5:0]  prefix_length;
    } cfg_t;

    // one closed packet, waiting for its verdict
    typedef struct packed {
        logic [31:0]          src;
        logic [31:0]          dst;
        logic [31:0]          ttl;
        logic [31:0]          given;
        logic [HDR_SUM_W-1:0] hdr_sum;
        logic [SUM_W-1:0]     pay_sum;
        logic                 bad;
    } job_t;

    function automatic logic [9:0] byte_sum32(input logic [31:0] v);
        return 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
    endfunction

    function automatic logic [8:0] byte_sum16(input logic [15:0] v);
        return 9'(v[7:0]) + 9'(v[15:8]);
    endfunction

endpackage

// ----- hw/rtl/l3_forward_nat_checksum_top.sv -----
// l3_forward_nat_checksum_top: top level with configuration registers, front,
// job queue and verdict back end. Depends on l3fn_pkg, l3fn_front, l3fn_queue, l3fn_back.
//
// Usage
//   Input stream: one header item (tuser = 0) followed by payload byte items
//   (tuser = 1); tlast closes the packet. A header with tlast has no payload.
//   Each closed packet yields exactly one item on the output stream carrying
//   the verdict, the source address after NAT, the decremented TTL and the
//   adjusted checksum; dropped packets carry zeros in the three word fields.
//   Payload outside a packet is discarded; a header inside a packet abandons it.
//   Configuration: APB, nic_address at 0x0, prefix_length at 0x4; write only
//   while no packet is in flight.
// Timing
//   One item per cycle, sustained while the job queue has room. The front adds
//   up the header bytes in the cycle it takes the header and accumulates one
//   payload byte per cycle. A closing item passes through the queue, the
//   classify stage and the output register on its way to the output.
// Reset and stall
//   Reset clears the packet state, the queue and both pipeline valids, and
//   loads nic_address = 0, prefix_length = 24. While m_tready is low the
//   output and classify stages hold and the queue fills; s_tready drops only
//   once FIFO_DEPTH closed packets wait.
module l3_forward_nat_checksum_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [l3fn_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // source_address, dest_address, hop_limit, given_sum, source_port,
    // dest_port, segment_index, payload_byte
    input  logic [l3fn_pkg::IN_DATA_W-1:0]    s_tdata,
    // func
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // verdict, out_source_address, out_hop_limit, out_sum, zero pad
    output logic [l3fn_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import l3fn_pkg::*;

    logic [31:0] nic_address_reg;
    logic [5:0]  prefix_length_reg;
    logic        cfg_write;
    cfg_t        cfg;

    logic        q_full;
    logic        push;
    job_t        push_job;
    logic        q_valid;
    logic        pop;
    job_t        head_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nic_address_reg   <= 32'd0;
            prefix_length_reg <= 6'd24;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_NIC_ADDRESS)
                nic_address_reg <= pwdata;
            else
                prefix_length_reg <= pwdata[5:0];
        end
    end

    assign prdata = (paddr[2] == REG_PREFIX_LENGTH) ? {26'd0, prefix_length_reg}
                                                    : nic_address_reg;

    assign cfg.nic_address   = nic_address_reg;
    assign cfg.prefix_length = prefix_length_reg;

    l3fn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    l3fn_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .q_valid  (q_valid),
        .pop      (pop),
        .head_job (head_job)
    );

    l3fn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .head_job (head_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- hw/rtl/l3fn_front.sv -----
// l3fn_front: accepts header and payload items, keeps the running byte sum,
// and pushes a job into the queue when a packet closes. Depends on l3fn_pkg.
module l3fn_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [l3fn_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    input  logic                             q_full,
    output logic                             push,
    output l3fn_pkg::job_t                   push_job
);
    import l3fn_pkg::*;

    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ttl;
    logic [31:0] given;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] idx;
    logic [7:0]  pbyte;

    logic                 accept;
    logic                 is_hdr;
    logic                 is_pay;
    logic [HDR_SUM_W-1:0] hdr_sum;
    logic [SUM_W:0]       pay_add;

    logic                 in_packet_reg, in_packet_next;
    logic                 bad_reg;
    logic [HDR_SUM_W-1:0] hdr_sum_reg;
    logic [SUM_W-1:0]     pay_sum_reg, pay_sum_next;
    logic [31:0]          src_reg, dst_reg, ttl_reg, given_reg;

    assign src   = s_tdata[31:0];
    assign dst   = s_tdata[63:32];
    assign ttl   = s_tdata[95:64];
    assign given = s_tdata[127:96];
    assign sport = s_tdata[143:128];
    assign dport = s_tdata[159:144];
    assign idx   = s_tdata[191:160];
    assign pbyte = s_tdata[199:192];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_hdr   = accept && (s_tuser == FUNC_HEADER);
    // payload outside a packet is dropped silently
    assign is_pay   = accept && (s_tuser == FUNC_PAYLOAD) && in_packet_reg;

    // header sum is at most 20 * 255, so it never reaches the cap
    assign hdr_sum = 13'(byte_sum32(src)) + 13'(byte_sum32(dst)) + 13'(byte_sum32(ttl))
                   + 13'(byte_sum16(sport)) + 13'(byte_sum16(dport)) + 13'(byte_sum32(idx));

    assign pay_add      = {1'b0, pay_sum_reg} + (SUM_W+1)'(pbyte);
    assign pay_sum_next = pay_add[SUM_W] ? SUM_CAP : pay_add[SUM_W-1:0];

    always_comb
    begin
        in_packet_next = in_packet_reg;
        if (is_hdr)
            in_packet_next = !s_tlast;
        else if (is_pay && s_tlast)
            in_packet_next = 1'b0;
    end

    assign push = (is_hdr || is_pay) && s_tlast;

    always_comb
    begin
        if (is_hdr)
        begin
            push_job.src     = src;
            push_job.dst     = dst;
            push_job.ttl     = ttl;
            push_job.given   = given;
            push_job.hdr_sum = hdr_sum;
            push_job.pay_sum = '0;
            push_job.bad     = (ttl == 32'd0) || (idx > INDEX_MAX);
        end
        else
        begin
            push_job.src     = src_reg;
            push_job.dst     = dst_reg;
            push_job.ttl     = ttl_reg;
            push_job.given   = given_reg;
            push_job.hdr_sum = hdr_sum_reg;
            push_job.pay_sum = pay_sum_next;
            push_job.bad     = bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            bad_reg       <= 1'b0;
            hdr_sum_reg   <= '0;
            pay_sum_reg   <= '0;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
            if (is_hdr)
            begin
                bad_reg     <= (ttl == 32'd0) || (idx > INDEX_MAX);
                hdr_sum_reg <= hdr_sum;
                pay_sum_reg <= '0;
            end
            else if (is_pay)
            begin
                pay_sum_reg <= pay_sum_next;
            end
        end
    end

    // held header fields, no reset
    always_ff @(posedge clk)
    begin
        if (is_hdr)
        begin
            src_reg   <= src;
            dst_reg   <= dst;
            ttl_reg   <= ttl;
            given_reg <= given;
        end
    end

    a_hdr_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == FUNC_HEADER) && !s_tlast) |=> in_packet_reg)
        else $error("header without last did not open a packet");

endmodule

// ----- hw/rtl/l3fn_queue.sv -----
// l3fn_queue: short job queue between front and back.
// Depends on l3fn_pkg for job_t.
module l3fn_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  l3fn_pkg::job_t push_job,
    output logic           full,
    output logic           q_valid,
    input  logic           pop,
    output l3fn_pkg::job_t head_job
);
    import l3fn_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("job popped from an empty queue");

endmodule

// ----- hw/rtl/l3fn_back.sv -----
// l3fn_back: two-stage verdict pipeline; stage one classifies and works out the
// checksum delta, stage two adds it and holds the result. Depends on l3fn_pkg.
module l3fn_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  l3fn_pkg::cfg_t                  cfg,
    input  logic                            q_valid,
    input  l3fn_pkg::job_t                  head_job,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [l3fn_pkg::OUT_DATA_W-1:0] m_tdata
);
    import l3fn_pkg::*;

    logic [SUM_W:0]   total;
    logic [SUM_W-1:0] total_sat;
    logic             sum_ok;
    logic [31:0]      mask;
    logic             sl, dl;
    logic [31:0]      ttl_m1;
    logic [31:0]      delta;
    verdict_t         verdict;
    logic [31:0]      v_src, v_ttl, v_given, v_delta;

    logic             out_take, s1_take;

    logic             s1_valid_reg;
    verdict_t         s1_verdict_reg;
    logic [31:0]      s1_src_reg, s1_ttl_reg, s1_given_reg, s1_delta_reg;

    logic             out_valid_reg;
    verdict_t         out_verdict_reg;
    logic [31:0]      out_src_reg, out_ttl_reg, out_sum_reg;

    // saturated running sum of the packet
    assign total     = (SUM_W+1)'(head_job.hdr_sum) + {1'b0, head_job.pay_sum};
    assign total_sat = total[SUM_W] ? SUM_CAP : total[SUM_W-1:0];
    assign sum_ok    = ({8'd0, total_sat} == head_job.given) && !head_job.bad;

    // prefix of 32 or more is an exact match, 0 matches everything
    assign mask = (cfg.prefix_length >= 6'd32) ? 32'hFFFF_FFFF
                                               : ~(32'hFFFF_FFFF >> cfg.prefix_length[4:0]);
    assign sl   = ((head_job.src & mask) == (cfg.nic_address & mask));
    assign dl   = ((head_job.dst & mask) == (cfg.nic_address & mask));

    assign ttl_m1 = head_job.ttl - 32'd1;

    always_comb
    begin
        delta = 32'(byte_sum32(ttl_m1)) - 32'(byte_sum32(head_job.ttl));
        if (sl)
            delta = delta + 32'(byte_sum32(cfg.nic_address))
                          - 32'(byte_sum32(head_job.src));
    end

    always_comb
    begin
        verdict = VERDICT_INVALID;
        v_src   = '0;
        v_ttl   = '0;
        v_given = '0;
        v_delta = '0;
        if (!sum_ok)
            verdict = VERDICT_INVALID;
        else if (head_job.dst == cfg.nic_address)
        begin
            verdict = VERDICT_LOCAL_L4;
            v_src   = head_job.src;
            v_ttl   = head_job.ttl;
            v_given = head_job.given;
        end
        else if (sl && dl)
            verdict = VERDICT_LOCAL_DROP;
        else if (head_job.ttl <= 32'd1)
            verdict = VERDICT_TTL_EXPIRED;
        else
        begin
            verdict = dl ? VERDICT_RX_QUEUE : VERDICT_TX_QUEUE;
            v_src   = sl ? cfg.nic_address : head_job.src;
            v_ttl   = ttl_m1;
            v_given = head_job.given;
            v_delta = delta;
        end
    end

    assign out_take = !out_valid_reg || m_tready;
    assign s1_take  = !s1_valid_reg || out_take;
    assign pop      = q_valid && s1_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
                s1_valid_reg <= q_valid;
            if (out_take)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_verdict_reg <= verdict;
            s1_src_reg     <= v_src;
            s1_ttl_reg     <= v_ttl;
            s1_given_reg   <= v_given;
            s1_delta_reg   <= v_delta;
        end
        if (out_take && s1_valid_reg)
        begin
            out_verdict_reg <= s1_verdict_reg;
            out_src_reg     <= s1_src_reg;
            out_ttl_reg     <= s1_ttl_reg;
            out_sum_reg     <= s1_given_reg + s1_delta_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_sum_reg, out_ttl_reg, out_src_reg, out_verdict_reg};

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_verdict_reg == VERDICT_INVALID ||
                           out_verdict_reg == VERDICT_LOCAL_DROP ||
                           out_verdict_reg == VERDICT_TTL_EXPIRED))
        |-> (out_src_reg == '0 && out_ttl_reg == '0 && out_sum_reg == '0))
        else $error("dropped packet carries non-zero fields");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_take)
        |=> (s1_valid_reg && $stable(s1_given_reg) && $stable(s1_delta_reg)))
        else $error("stage one lost its job under stall");

endmodule

// ----- bench/l3fn_forward_checker.sv -----
// Checker for l3_forward_nat_checksum_top: watches APB writes and both item
// streams, predicts each verdict item and compares it field by field.
// Depends on l3fn_pkg for widths, item kinds, register indexes and verdict codes.
module l3fn_forward_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [l3fn_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [l3fn_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [l3fn_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                              mismatches,
    output int                              waiting
);
    import l3fn_pkg::*;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] src_addr;
        logic [31:0] hop;
        logic [31:0] csum;
    } fwd_result_t;

    logic [31:0]     nic_addr;
    logic [5:0]      prefix_len;
    logic [SUM_W-1:0] pkt_sum;
    logic [31:0]     hdr_src;
    logic [31:0]     hdr_dst;
    logic [31:0]     hdr_ttl;
    logic [31:0]     hdr_given;
    logic            hdr_bad;
    logic            pkt_open;
    fwd_result_t     verdict_queue[$];
    int              result_no;

    function automatic logic [9:0] byte_total(input logic [31:0] v);
        return 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
    endfunction

    // running sum sticks at its ceiling
    task automatic accumulate(input logic [9:0] v);
        logic [SUM_W:0] s;
        s = pkt_sum + v;
        pkt_sum = (s > SUM_CAP) ? SUM_CAP : s[SUM_W-1:0];
    endtask

    function automatic bit on_link(input logic [31:0] a);
        logic [31:0] keep;
        if (prefix_len >= 6'd32)
            return a == nic_addr;
        if (prefix_len == 6'd0)
            return 1'b1;
        keep = 32'hFFFF_FFFF << (32 - int'(prefix_len));
        return (a & keep) == (nic_addr & keep);
    endfunction

    function automatic fwd_result_t forward_verdict();
        fwd_result_t r;
        bit          src_in;
        bit          dst_in;
        logic [31:0] cs;
        r = '0;
        r.verdict = VERDICT_INVALID;
        if (hdr_bad || {8'h00, pkt_sum} != hdr_given)
            return r;
        if (hdr_dst == nic_addr)
        begin
            r.verdict  = VERDICT_LOCAL_L4;
            r.src_addr = hdr_src;
            r.hop      = hdr_ttl;
            r.csum     = hdr_given;
            return r;
        end
        src_in = on_link(hdr_src);
        dst_in = on_link(hdr_dst);
        if (src_in && dst_in)
        begin
            r.verdict = VERDICT_LOCAL_DROP;
            return r;
        end
        if (hdr_ttl <= 32'd1)
        begin
            r.verdict = VERDICT_TTL_EXPIRED;
            return r;
        end
        cs = hdr_given + byte_total(hdr_ttl - 32'd1) - byte_total(hdr_ttl);
        r.verdict  = VERDICT_TX_QUEUE;
        r.src_addr = hdr_src;
        r.hop      = hdr_ttl - 32'd1;
        if (src_in)
        begin
            // source NAT onto the interface address
            cs = cs - byte_total(hdr_src) + byte_total(nic_addr);
            r.src_addr = nic_addr;
        end
        else if (dst_in)
            r.verdict = VERDICT_RX_QUEUE;
        r.csum = cs;
        return r;
    endfunction

    task automatic take_item(input logic func, input logic [IN_DATA_W-1:0] d,
                             input logic last);
        if (func == FUNC_HEADER)
        begin
            hdr_src   = d[31:0];
            hdr_dst   = d[63:32];
            hdr_ttl   = d[95:64];
            hdr_given = d[127:96];
            hdr_bad   = (d[95:64] == 32'd0) || (d[191:160] > INDEX_MAX);
            pkt_sum   = '0;
            accumulate(byte_total(d[31:0]));
            accumulate(byte_total(d[63:32]));
            accumulate(byte_total(d[95:64]));
            accumulate(byte_total({16'h0000, d[143:128]}));
            accumulate(byte_total({16'h0000, d[159:144]}));
            accumulate(byte_total(d[191:160]));
            pkt_open  = 1'b1;
        end
        else
        begin
            if (!pkt_open)
                return;
            accumulate(10'(d[199:192]));
        end
        if (last)
        begin
            pkt_open = 1'b0;
            verdict_queue.insert(verdict_queue.size(), forward_verdict());
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("checker: result %0d %s: expected %h, got %h", result_no, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fwd_result_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            result_no  = 0;
            nic_addr   = 32'h0;
            prefix_len = 6'd24;
            pkt_sum    = '0;
            hdr_bad    = 1'b0;
            pkt_open   = 1'b0;
            verdict_queue.delete();
            waiting   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_NIC_ADDRESS)
                    nic_addr = pwdata;
                else
                    prefix_len = pwdata[5:0];
            end
            if (s_tvalid && s_tready)
                take_item(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                result_no++;
                if (verdict_queue.size() == 0)
                    report_mismatch("unexpected, verdict", 32'd0, 32'(m_tdata[2:0]));
                else
                begin
                    want = verdict_queue.pop_front();
                    if (m_tdata[2:0] != want.verdict)
                        report_mismatch("verdict", 32'(want.verdict), 32'(m_tdata[2:0]));
                    if (m_tdata[34:3] != want.src_addr)
                        report_mismatch("source address", want.src_addr, m_tdata[34:3]);
                    if (m_tdata[66:35] != want.hop)
                        report_mismatch("hop limit", want.hop, m_tdata[66:35]);
                    if (m_tdata[98:67] != want.csum)
                        report_mismatch("checksum", want.csum, m_tdata[98:67]);
                    if (m_tdata[OUT_DATA_W-1:99] != '0)
                        report_mismatch("pad", 32'd0, 32'(m_tdata[OUT_DATA_W-1:99]));
                end
            end
            waiting <= verdict_queue.size();
        end
    end

endmodule

// ----- bench/l3_forward_nat_checksum_top_tb.sv -----
// Testbench top for l3_forward_nat_checksum_top: clock, reset, APB programming,
// packet stimulus and result back-pressure; verdict from l3fn_forward_checker.
// Depends on l3fn_pkg, l3_forward_nat_checksum_top and l3fn_forward_checker.
module l3_forward_nat_checksum_top_tb;
    import l3fn_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES   = 16;     // queue + classify + output, with margin
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int PHASE_ITEMS    = 120;
    localparam int NUM_PHASES     = 8;
    localparam int LONG_BYTES     = 64;     // long packet of 0xFF bytes

    // address classes relative to the current subnet
    localparam int ADDR_NIC      = 0;
    localparam int ADDR_LOCAL    = 1;
    localparam int ADDR_EXTERNAL = 2;
    localparam int ADDR_ANY      = 3;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // source_address, dest_address, hop_limit, given_sum, source_port,
    // dest_port, segment_index, payload_byte (lowest bits first)
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // func
    logic                  s_tuser  = 1'b0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // verdict, out_source_address, out_hop_limit, out_sum, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatches;
    int waiting;
    int cycle_count = 0;
    int item_count  = 0;

    // stimulus-side copy of the programmed registers, used to aim addresses
    logic [31:0] stim_nic    = 32'h0;
    int          stim_prefix = 24;

    bit no_idle   = 1'b0;   // both sides run flat out while set
    bit sink_hold = 1'b0;   // asks the receiver for one long hold-off

    l3_forward_nat_checksum_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    l3fn_forward_checker fwd_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog: a correct run finishes far inside this
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[l3_forward_nat_checksum_top] ERROR");
        $finish;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [31:0] octet_sum(input logic [31:0] v);
        return v[7:0] + v[15:8] + v[23:16] + v[31:24];
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_in(
        input logic [31:0] src, input logic [31:0] dst, input logic [31:0] ttl,
        input logic [31:0] given, input logic [15:0] sport, input logic [15:0] dport,
        input logic [31:0] idx, input logic [7:0] pbyte);
        return {pbyte, idx, dport, sport, given, ttl, dst, src};
    endfunction

    // Address aimed at a class of the current subnet. An oversized prefix
    // behaves as /32, so "local" collapses onto the interface address.
    function automatic logic [31:0] pick_addr(input int kind);
        logic [31:0] keep;
        logic [31:0] host;
        int          p;
        p    = (stim_prefix > 32) ? 32 : stim_prefix;
        keep = (p == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - p));
        host = (stim_nic & keep) | ($urandom & ~keep);
        case (kind)
            ADDR_NIC:      return stim_nic;
            ADDR_LOCAL:    return host;
            ADDR_EXTERNAL: return (p == 0) ? $urandom : host ^ (32'h1 << (32 - $urandom_range(1, p)));
            default:       return $urandom;
        endcase
    endfunction

    function automatic int pick_class(input int nic_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < nic_pct)
            return ADDR_NIC;
        if (r < nic_pct + 40)
            return ADDR_LOCAL;
        if (r < 90)
            return ADDR_EXTERNAL;
        return ADDR_ANY;
    endfunction

    // One item: optional idle gap, then hold it until the block takes it.
    // s_tvalid stays high into the next item when that one has no gap.
    task automatic send_item(input logic func, input logic [IN_DATA_W-1:0] d,
                             input logic last);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= func;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // Header plus n_pay payload items. Checksum is made correct unless
    // corrupt is set; closes = 0 leaves the packet open (abandoned later).
    // fill < 0 gives random payload, else every byte is fill.
    task automatic send_packet(
        input logic [31:0] src, input logic [31:0] dst, input logic [31:0] ttl,
        input logic [15:0] sport, input logic [15:0] dport, input logic [31:0] idx,
        input int n_pay, input bit corrupt, input bit closes, input int fill);
        logic [7:0]  pay[$];
        logic [31:0] sum;
        logic [31:0] given;
        for (int k = 0; k < n_pay; k++)
            pay.insert(pay.size(), (fill < 0) ? 8'($urandom) : 8'(fill));
        sum = octet_sum(src) + octet_sum(dst) + octet_sum(ttl) + octet_sum({16'h0, sport})
            + octet_sum({16'h0, dport}) + octet_sum(idx);
        foreach (pay[i])
            sum += pay[i];
        if (sum > SUM_CAP)
            sum = SUM_CAP;
        given = sum;
        if (corrupt)
        begin
            given = ($urandom_range(0, 1) == 1) ? $urandom : sum ^ (32'h1 << $urandom_range(0, 15));
            if (given == sum)
                given = ~sum;
        end
        send_item(FUNC_HEADER, pack_in(src, dst, ttl, given, sport, dport, idx, 8'($urandom)),
                  closes && n_pay == 0);
        for (int k = 0; k < n_pay; k++)
            send_item(FUNC_PAYLOAD,
                      pack_in($urandom, $urandom, $urandom, $urandom, 16'($urandom),
                              16'($urandom), $urandom, pay[k]),
                      closes && k == n_pay - 1);
        if (closes)
            item_count += 1 + n_pay;
    endtask

    // Mostly well-formed packets with random content; a little noise:
    // stray payload items and packets cut short by the next header.
    task automatic random_packet();
        int          r;
        int          n_pay;
        logic [31:0] ttl;
        logic [31:0] idx;
        r = $urandom_range(0, 99);
        if (r < 6)
            ttl = 32'd0;
        else if (r < 12)
            ttl = 32'd1;
        else if (r < 16)
            ttl = 32'd2;
        else if (r < 20)
            ttl = 32'hFFFF_FFFF;
        else if (r < 40)
            ttl = $urandom;
        else
            ttl = $urandom_range(3, 255);
        r = $urandom_range(0, 99);
        if (r < 85)
            idx = $urandom_range(0, 63);
        else if (r < 88)
            idx = 32'd64;
        else if (r < 90)
            idx = 32'hFFFF_FFFF;
        else
            idx = $urandom;
        r = $urandom_range(0, 99);
        if (r < 25)
            n_pay = 0;
        else if (r < 80)
            n_pay = $urandom_range(1, 8);
        else
            n_pay = $urandom_range(9, 32);
        r = $urandom_range(0, 99);
        if (r < 6)
            send_item(FUNC_PAYLOAD,
                      pack_in($urandom, $urandom, $urandom, $urandom, 16'($urandom),
                              16'($urandom), $urandom, 8'($urandom)),
                      1'($urandom_range(0, 1)));
        else if (r < 11)
            send_packet(pick_addr(ADDR_ANY), pick_addr(ADDR_ANY), $urandom, 16'($urandom),
                        16'($urandom), $urandom_range(0, 63), $urandom_range(0, 4), 1'b0,
                        1'b0, -1);
        if ($urandom_range(0, 19) == 0)
            no_idle = !no_idle;
        send_packet(pick_addr(pick_class(10)), pick_addr(pick_class(20)), ttl,
                    16'($urandom), 16'($urandom), idx, n_pay, $urandom_range(0, 9) == 0,
                    1'b1, -1);
    endtask

    // Let every expected result arrive, then give the front time to finish
    // items that produce nothing before touching the registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both registers, back to back: setup then access for each.
    task automatic apb_program(input logic [31:0] nic, input logic [5:0] prefix);
        logic idx;
        for (int k = 0; k < 2; k++)
        begin
            idx = (k == 0) ? REG_NIC_ADDRESS : REG_PREFIX_LENGTH;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= (k == 0) ? nic : {26'h0, prefix};
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel        <= 1'b0;
        penable     <= 1'b0;
        stim_nic     = nic;
        stim_prefix  = int'(prefix);
    endtask

    // Receiver: random stall before each result, or one long hold-off on request.
    initial
    begin : sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = idle_draw();
            if (sink_hold)
            begin
                sink_hold = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin : main_seq
        logic [31:0] nic_plan [NUM_PHASES];
        logic [5:0]  pre_plan [NUM_PHASES];
        int          target;

        // register settings per random phase; extremes of both fields,
        // prefix 40 and 63 exercise the oversized-prefix behaviour
        nic_plan = '{32'hC0A8_0A01, 32'h0A00_0001, $urandom, $urandom,
                     32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom};
        pre_plan = '{6'd24, 6'd8, 6'd0, 6'd32, 6'd40, 6'd16,
                     6'($urandom_range(1, 31)), 6'd63};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: nic 0.0.0.0/24, so dest 0 goes to L4 and
        // two hosts in 0.0.0.x are local to local
        send_packet(32'hFFFF_FFFF, 32'h0, 32'd7, 16'h0, 16'h0, 32'd0, 0, 1'b0, 1'b1, -1);
        send_packet(32'h0000_00AB, 32'h0000_0012, 32'd64, 16'hFFFF, 16'h0, 32'd1, 0,
                    1'b0, 1'b1, -1);
        settle();
        apb_program(32'hC0A8_0A01, 6'd24);

        // directed: every verdict but local drop, and the special cases
        send_packet(32'h0808_0808, 32'h0101_0101, 32'd1, 16'h0, 16'hFFFF, 32'd0, 0,
                    1'b0, 1'b1, -1);                                    // ttl expired
        send_packet(32'h0808_0808, 32'hC0A8_0A37, 32'd0, 16'h1234, 16'h0, 32'd3, 0,
                    1'b0, 1'b1, -1);                                    // ttl zero
        send_packet(32'h0808_0808, 32'hC0A8_0A37, 32'd9, 16'h0, 16'h0, 32'd64, 0,
                    1'b0, 1'b1, -1);                                    // index past 63
        send_packet(32'h0808_0808, 32'hC0A8_0A37, 32'd9, 16'hFFFF, 16'hFFFF,
                    32'hFFFF_FFFF, 0, 1'b0, 1'b1, -1);
        send_packet(32'h0808_0808, 32'h0101_0101, 32'd30, 16'h55AA, 16'hAA55, 32'd7, 1,
                    1'b1, 1'b1, -1);                                    // bad checksum
        send_packet(32'hC0A8_0A37, 32'h0808_0808, 32'hFFFF_FFFF, 16'h0, 16'hFFFF,
                    32'd63, 2, 1'b0, 1'b1, -1);                         // NAT out
        send_packet(32'h0101_0101, 32'hC0A8_0A99, 32'd2, 16'hFFFF, 16'h0, 32'd5, 0,
                    1'b0, 1'b1, -1);                                    // inbound
        send_packet(32'h0808_0808, 32'h0101_0101, 32'd200, 16'h0, 16'h0, 32'd0, 1,
                    1'b0, 1'b1, -1);                                    // transit
        // payload with no packet open is dropped silently
        send_item(FUNC_PAYLOAD, pack_in('1, '1, '1, '1, '1, '1, '1, 8'hFF), 1'b1);
        // header while a packet is open abandons the old one
        send_packet(32'h0808_0808, 32'hC0A8_0A37, 32'd9, 16'h0, 16'h0, 32'd0, 1,
                    1'b0, 1'b0, -1);
        send_packet(32'hFFFF_FFFF, 32'hC0A8_0A01, 32'd1, 16'h0, 16'h0, 32'd0, 0,
                    1'b0, 1'b1, -1);                                    // L4 despite ttl 1

        target = item_count;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            apb_program(nic_plan[ph], pre_plan[ph]);
            if (ph == 1)
            begin
                // back-pressure: receiver stops for a long stretch while short
                // packets keep coming, so the job queue fills and s_tready drops
                no_idle   = 1'b1;
                sink_hold = 1'b1;
                repeat (24)
                    send_packet(pick_addr(ADDR_EXTERNAL), pick_addr(ADDR_LOCAL),
                                $urandom_range(3, 255), 16'($urandom), 16'($urandom),
                                $urandom_range(0, 63), 0, 1'b0, 1'b1, -1);
                no_idle   = 1'b0;
            end
            target += PHASE_ITEMS;
            while (item_count < target)
                random_packet();
            no_idle = 1'b0;
        end

        // long packet of all-0xFF payload bytes sent flat out
        settle();
        no_idle = 1'b1;
        send_packet(pick_addr(ADDR_EXTERNAL), pick_addr(ADDR_ANY), 32'd64, 16'hFFFF,
                    16'hFFFF, 32'd63, LONG_BYTES, 1'b0, 1'b1, 8'hFF);
        no_idle = 1'b0;
        settle();

        if (mismatches == 0 && waiting == 0)
            $display("[l3_forward_nat_checksum_top] OK");
        else
            $display("[l3_forward_nat_checksum_top] ERROR");
        $finish;
    end

endmodule
